// ===== hdl/hex_field_formatter_unit_defines.svh =====
// Assertion macros used by the checker file of the hex field formatter.
`ifndef HEX_FIELD_FORMATTER_UNIT_DEFINES_SVH
`define HEX_FIELD_FORMATTER_UNIT_DEFINES_SVH

// Checked while out of reset.
`define HFFU_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define HFFU_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/hffu_pkg.sv =====
// Package of the hex field formatter: word types, layout plan and digit tables.
`default_nettype none
package hffu_pkg;

    localparam int MAX_CHARS = 64;
    localparam int CNT_W     = 7;
    localparam int Q_DEPTH   = 2;

    typedef struct packed {
        logic [63:0] value;
        logic        uppercase;
        logic        alternate_form;
        logic        left_justify;
        logic        zero_fill;
        logic [6:0]  field_width;
        logic [5:0]  min_digits;
    } t_in_word;

    typedef struct packed {
        logic [7:0]  out_char;
        logic        last;
        logic [6:0]  char_count;
    } t_out_word;

    // Layout of one field as position boundaries, each the end of a segment.
    typedef struct packed {
        logic [63:0]      value;
        logic             upper;
        logic [CNT_W-1:0] b_lead;
        logic [CNT_W-1:0] b_pfx;
        logic [CNT_W-1:0] b_zero;
        logic [CNT_W-1:0] b_dig;
        logic [CNT_W-1:0] total;
        logic [3:0]       nib_top;
    } t_plan;

    typedef enum logic {
        BK_IDLE,
        BK_EMIT
    } t_back_state;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;

    localparam logic [7:0] DIGITS_LO [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };
    localparam logic [7:0] DIGITS_UP [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

    function automatic logic [7:0] hex_digit(input logic [3:0] nib, input logic upper);
        return upper ? DIGITS_UP[nib] : DIGITS_LO[nib];
    endfunction

endpackage
`default_nettype wire

// ===== hdl/hex_field_formatter_unit.sv =====
// Top level of the hex field formatter: front end, plan queue and character sequencer.
//
//  channel  direction  handshake           word
//  input    in         i_valid / o_ready   i_data  (value, flags, width, precision)
//  output   out        o_valid / i_ready   o_data  (out_char, last, char_count)
//
// A field of N characters (1 to 64) leaves at one character per cycle while the output
// is not stalled; the sequencer loads the next plan in its idle state between fields.
// The front end takes a new word whenever the two-entry plan queue has room.
// A stall on the output holds the sequencer; once the queue is full the input waits too.
// Reset is synchronous and leaves the queue empty and no output word pending.
`default_nettype none
module hex_field_formatter_unit (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  hffu_pkg::t_in_word   i_data,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output hffu_pkg::t_out_word  o_data
);
    import hffu_pkg::*;

    logic  push;
    logic  push_ready;
    t_plan front_plan;
    logic  q_valid;
    logic  q_pop;
    t_plan q_plan;

    hffu_front u_front (
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data       (i_data),
        .o_push       (push),
        .i_push_ready (push_ready),
        .o_plan       (front_plan)
    );

    hffu_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_push_ready (push_ready),
        .i_plan       (front_plan),
        .o_valid      (q_valid),
        .i_pop        (q_pop),
        .o_plan       (q_plan)
    );

    hffu_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_plan_valid (q_valid),
        .o_pop        (q_pop),
        .i_plan       (q_plan),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_data       (o_data)
    );

endmodule
`default_nettype wire

// ===== hdl/hffu_front.sv =====
// Front end: accepts a word and works out the segment layout of its field.
`default_nettype none
module hffu_front (
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  hffu_pkg::t_in_word    i_data,
    output logic                  o_push,
    input  wire logic             i_push_ready,
    output hffu_pkg::t_plan       o_plan
);
    import hffu_pkg::*;

    localparam logic [CNT_W-1:0] WMAX = CNT_W'(MAX_CHARS);
    localparam logic [5:0]       PMAX = 6'(MAX_CHARS - 2);

    logic [3:0]       top;
    logic [CNT_W-1:0] w;
    logic [5:0]       p;
    logic [CNT_W-1:0] len;
    logic [CNT_W-1:0] zpad;
    logic [CNT_W-1:0] body;
    logic [CNT_W-1:0] spad;
    logic [CNT_W-1:0] lead;
    logic [CNT_W-1:0] zfill;
    logic             prefix;

    assign o_ready = i_push_ready;
    assign o_push  = i_valid;

    always_comb begin
        // Highest nonzero nibble; a zero value still prints one digit.
        top = 4'd0;
        for (int i = 0; i < 16; i++) begin
            if (i_data.value[i*4 +: 4] != 4'd0) begin
                top = 4'(i);
            end
        end
        prefix = i_data.alternate_form && (i_data.value != 64'd0);
        w      = (i_data.field_width > WMAX) ? WMAX : i_data.field_width;
        p      = (i_data.min_digits > PMAX) ? PMAX : i_data.min_digits;
        len    = CNT_W'(top) + CNT_W'(1);
        zpad   = (CNT_W'(p) > len) ? CNT_W'(p) - len : '0;
        body   = len + zpad + (prefix ? CNT_W'(2) : CNT_W'(0));
        spad   = (w > body) ? w - body : '0;
        lead   = (!i_data.left_justify && !i_data.zero_fill) ? spad : '0;
        zfill  = (!i_data.left_justify && i_data.zero_fill) ? spad : '0;

        o_plan.value   = i_data.value;
        o_plan.upper   = i_data.uppercase;
        o_plan.nib_top = top;
        o_plan.b_lead  = lead;
        o_plan.b_pfx   = lead + (prefix ? CNT_W'(2) : CNT_W'(0));
        o_plan.b_zero  = o_plan.b_pfx + zpad + zfill;
        o_plan.b_dig   = o_plan.b_zero + len;
        o_plan.total   = body + spad;
    end

endmodule
`default_nettype wire

// ===== hdl/hffu_queue.sv =====
// Short queue of field plans between the front end and the character sequencer.
`default_nettype none
module hffu_queue (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    output logic             o_push_ready,
    input  hffu_pkg::t_plan  i_plan,
    output logic             o_valid,
    input  wire logic        i_pop,
    output hffu_pkg::t_plan  o_plan
);
    import hffu_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_QW = $clog2(Q_DEPTH + 1);

    t_plan             r_mem [Q_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_QW-1:0] r_count, n_count;
    logic              do_push;
    logic              do_pop;

    assign o_push_ready = (r_count != CNT_QW'(Q_DEPTH));
    assign o_valid      = (r_count != '0);
    assign o_plan       = r_mem[r_rd_ptr];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_valid;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] ptr);
        return (ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
    endfunction

    always_comb begin
        n_wr_ptr = do_push ? bump(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = do_pop ? bump(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count + CNT_QW'(do_push) - CNT_QW'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_plan;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/hffu_back.sv =====
// Back end: walks a field plan and sends one character word per cycle unless the output stalls.
`default_nettype none
module hffu_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_plan_valid,
    output logic               o_pop,
    input  hffu_pkg::t_plan    i_plan,
    output logic               o_valid,
    input  wire logic          i_ready,
    output hffu_pkg::t_out_word o_data
);
    import hffu_pkg::*;

    t_back_state      r_state, n_state;
    t_plan            r_plan, n_plan;
    logic [CNT_W-1:0] r_k, n_k;
    logic [3:0]       r_nib, n_nib;
    logic             r_out_valid, n_out_valid;
    t_out_word        r_out, n_out;
    logic             out_free;
    logic             is_last;
    logic             in_digits;
    logic [7:0]       ch;

    assign o_valid  = r_out_valid;
    assign o_data   = r_out;
    assign out_free = !r_out_valid || i_ready;
    assign is_last  = (r_k == r_plan.total - CNT_W'(1));
    assign in_digits = (r_k >= r_plan.b_zero) && (r_k < r_plan.b_dig);

    always_comb begin
        if (r_k < r_plan.b_lead) begin
            ch = CH_SPACE;
        end else if (r_k < r_plan.b_pfx) begin
            ch = (r_k == r_plan.b_lead) ? CH_ZERO : (r_plan.upper ? CH_X_UP : CH_X_LO);
        end else if (r_k < r_plan.b_zero) begin
            ch = CH_ZERO;
        end else if (r_k < r_plan.b_dig) begin
            ch = hex_digit(r_plan.value[r_nib*4 +: 4], r_plan.upper);
        end else begin
            ch = CH_SPACE;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_plan      = r_plan;
        n_k         = r_k;
        n_nib       = r_nib;
        n_out_valid = r_out_valid && !i_ready;
        n_out       = r_out;
        o_pop       = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (i_plan_valid) begin
                    o_pop   = 1'b1;
                    n_plan  = i_plan;
                    n_k     = '0;
                    n_nib   = i_plan.nib_top;
                    n_state = BK_EMIT;
                end
            end
            BK_EMIT: begin
                if (out_free) begin
                    n_out_valid      = 1'b1;
                    n_out.out_char   = ch;
                    n_out.last       = is_last;
                    n_out.char_count = is_last ? r_plan.total : '0;
                    n_k              = r_k + CNT_W'(1);
                    if (in_digits) begin
                        n_nib = r_nib - 4'd1;
                    end
                    if (is_last) begin
                        n_state = BK_IDLE;
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_plan <= n_plan;
        r_k    <= n_k;
        r_nib  <= n_nib;
        r_out  <= n_out;
    end

endmodule
`default_nettype wire

// ===== hdl/hffu_checker.sv =====
// Port-level checker of the hex field formatter and its bind to the top level.
`default_nettype none
`include "hex_field_formatter_unit_defines.svh"
module hffu_checker (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire logic            o_ready,
    input  hffu_pkg::t_in_word   i_data,
    input  wire logic            o_valid,
    input  wire logic            i_ready,
    input  hffu_pkg::t_out_word  o_data
);
    import hffu_pkg::*;

    // Characters delivered so far in the current field.
    logic [CNT_W-1:0] r_seen;
    logic             out_take;

    assign out_take = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else if (out_take) begin
            r_seen <= o_data.last ? '0 : r_seen + CNT_W'(1);
        end
    end

    `HFFU_ASSERT(a_in_hold, i_clk, i_rst_n, i_valid && !o_ready |=> i_valid && $stable(i_data), "input word changed while waiting")
    `HFFU_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_data), "output word changed while stalled")
    `HFFU_ASSERT(a_count_zero, i_clk, i_rst_n, o_valid && !o_data.last |-> o_data.char_count == '0 && r_seen < CNT_W'(MAX_CHARS - 1), "count shown before the last character or field too long")
    `HFFU_ASSERT(a_count_match, i_clk, i_rst_n, o_valid && o_data.last |-> o_data.char_count == r_seen + CNT_W'(1), "field length does not match the characters delivered")
    `HFFU_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !o_valid, "output word present right after reset")

endmodule

bind hex_field_formatter_unit hffu_checker u_hffu_checker (.*);
`default_nettype wire

// ===== tb/tb_hex_field_formatter_unit.sv =====
// Self-checking testbench for the hex field formatter: directed and random fields.
`timescale 1ns / 100ps
module tb_hex_field_formatter_unit;
    import hffu_pkg::*;

    // Worst case: about 525 fields of 64 characters, each character behind the longest
    // random stall; the limit is several times that.
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int RANDOM_FIELDS = 500;
    localparam logic [7:0] CH_A_UP = 8'h41;
    localparam logic [7:0] CH_A_LO = 8'h61;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    t_in_word   i_data;
    logic       o_valid;
    logic       i_ready;
    t_out_word  o_data;

    t_out_word  pending_chars[$];
    int         err_count = 0;
    int         cycle_count = 0;
    bit         in_idle = 1'b1;
    bit         out_idle = 1'b1;

    hex_field_formatter_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_hex_field_formatter_unit: done, errors");
            $finish;
        end
    end

    function automatic int idle_cycles(input bit enabled);
        return enabled ? int'($urandom_range(0, 19)) : 0;
    endfunction

    function automatic t_in_word make_word(input logic [63:0] value, input bit upper,
                                           input bit alt, input bit left, input bit zero,
                                           input int width, input int prec);
        t_in_word w;
        w.value          = value;
        w.uppercase      = upper;
        w.alternate_form = alt;
        w.left_justify   = left;
        w.zero_fill      = zero;
        w.field_width    = width[6:0];
        w.min_digits     = prec[5:0];
        return w;
    endfunction

    // Lays out the whole printf-style field and queues one word per character.
    function automatic void format_hex_field(input t_in_word w);
        logic [63:0] v;
        logic [3:0]  nib;
        logic [7:0]  chars[$];
        t_out_word   ow;
        int          width, prec, len, zpad, total, spad, n;
        bit          prefix;
        v     = w.value;
        width = (w.field_width > MAX_CHARS) ? MAX_CHARS : int'(w.field_width);
        prec  = (w.min_digits > MAX_CHARS - 2) ? MAX_CHARS - 2 : int'(w.min_digits);
        len   = 1;
        for (n = 0; n < 16; n++) begin
            if (v[4*n +: 4] != 4'h0) len = n + 1;
        end
        prefix = w.alternate_form && (v != 64'd0);
        zpad   = (prec > len) ? prec - len : 0;
        total  = len + zpad + (prefix ? 2 : 0);
        spad   = (width > total) ? width - total : 0;

        if (!w.left_justify && !w.zero_fill) repeat (spad) chars.push_back(CH_SPACE);
        if (prefix) begin
            chars.push_back(CH_ZERO);
            chars.push_back(w.uppercase ? CH_X_UP : CH_X_LO);
        end
        if (!w.left_justify && w.zero_fill) repeat (spad) chars.push_back(CH_ZERO);
        repeat (zpad) chars.push_back(CH_ZERO);
        for (n = len - 1; n >= 0; n--) begin
            nib = v[4*n +: 4];
            if (nib < 4'd10) chars.push_back(CH_ZERO + nib);
            else chars.push_back((w.uppercase ? CH_A_UP : CH_A_LO) + nib - 8'd10);
        end
        if (w.left_justify) repeat (spad) chars.push_back(CH_SPACE);

        for (n = 0; n < chars.size(); n++) begin
            ow.out_char   = chars[n];
            ow.last       = (n == chars.size() - 1);
            ow.char_count = ow.last ? 7'(chars.size()) : 7'd0;
            pending_chars.push_back(ow);
        end
    endfunction

    // Both handshakes are observed here, so a field is queued before any of its
    // characters can be checked.
    always @(posedge i_clk) begin : watch_channels
        t_out_word want;
        if (i_rst_n) begin
            if (i_valid && o_ready) format_hex_field(i_data);
            if (o_valid && i_ready) begin
                if (pending_chars.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected word, expected none, got %h", $time, o_data);
                end else begin
                    want = pending_chars.pop_front();
                    if (o_data.out_char !== want.out_char) begin
                        err_count++;
                        $display("%0t: out_char expected %h, got %h",
                                 $time, want.out_char, o_data.out_char);
                    end
                    if (o_data.last !== want.last) begin
                        err_count++;
                        $display("%0t: last expected %b, got %b",
                                 $time, want.last, o_data.last);
                    end
                    if (o_data.char_count !== want.char_count) begin
                        err_count++;
                        $display("%0t: char_count expected %0d, got %0d",
                                 $time, want.char_count, o_data.char_count);
                    end
                end
            end
        end
    end

    // Receiver: a random stall before each word, none while out_idle is clear.
    initial begin : drive_ready
        int gap;
        i_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = idle_cycles(out_idle);
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    task automatic send_word(input t_in_word w);
        int gap;
        gap = idle_cycles(in_idle);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= w;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Holds the input back until every queued character has come out.
    task automatic wait_all_chars();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_chars.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_value_zero();
        send_word(make_word(64'd0, 0, 1, 0, 0, 0, 0));
        send_word(make_word(64'd0, 1, 1, 0, 1, 5, 0));
        send_word(make_word(64'd0, 0, 0, 0, 0, 0, 4));
        send_word(make_word(64'd0, 1, 1, 1, 0, 3, 0));
        wait_all_chars();
    endtask

    task automatic test_case_and_prefix();
        send_word(make_word(64'hDEAD_BEEF_0123_4567, 0, 0, 0, 0, 0, 0));
        send_word(make_word(64'hDEAD_BEEF_0123_4567, 1, 0, 0, 0, 0, 0));
        send_word(make_word(64'h89AB_CDEF_FEDC_BA98, 0, 1, 0, 0, 0, 0));
        send_word(make_word(64'h89AB_CDEF_FEDC_BA98, 1, 1, 0, 0, 0, 0));
        send_word(make_word('1, 1, 1, 0, 0, 0, 0));
        send_word(make_word(64'd1, 0, 1, 0, 0, 0, 0));
        wait_all_chars();
    endtask

    task automatic test_padding_modes();
        send_word(make_word(64'h2a, 0, 0, 0, 0, 10, 0));
        send_word(make_word(64'h2a, 0, 1, 0, 1, 10, 0));
        send_word(make_word(64'h2a, 1, 1, 1, 0, 10, 0));
        // The zero flag loses to left justify.
        send_word(make_word(64'h2a, 0, 0, 1, 1, 10, 0));
        // The zero flag still applies when a precision is given.
        send_word(make_word(64'h2a, 1, 1, 0, 1, 12, 6));
        send_word(make_word(64'h2a, 0, 0, 0, 0, 12, 6));
        send_word(make_word(64'h12345, 0, 1, 0, 1, 3, 2));
        wait_all_chars();
    endtask

    task automatic test_saturation();
        send_word(make_word(64'd1, 0, 0, 0, 0, 127, 0));
        send_word(make_word(64'd1, 0, 0, 1, 0, 65, 0));
        send_word(make_word('1, 1, 1, 0, 0, 0, 63));
        send_word(make_word(64'h7, 0, 1, 1, 0, 64, 62));
        send_word(make_word('1, 0, 1, 0, 1, 64, 0));
        send_word(make_word(64'h0, 1, 0, 0, 1, 127, 63));
        wait_all_chars();
    endtask

    task automatic test_random_fields();
        logic [63:0] v;
        int          width, prec, k;
        for (k = 0; k < RANDOM_FIELDS; k++) begin
            // Change the idle pattern every so often, with stretches of none.
            if (k % 50 == 0) begin
                in_idle  = ($urandom_range(0, 2) != 0);
                out_idle = ($urandom_range(0, 2) != 0);
            end
            v = {$urandom, $urandom};
            case ($urandom_range(0, 7))
                0:       v = '1;
                1:       v = 64'd1 << $urandom_range(0, 63);
                default: v = v >> (4 * $urandom_range(0, 16));
            endcase
            // Most fields stay short; a few use the widest settings.
            if ($urandom_range(0, 9) == 0) begin
                width = $urandom_range(0, 127);
                prec  = $urandom_range(0, 63);
            end else begin
                width = $urandom_range(0, 20);
                prec  = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 18) : 0;
            end
            send_word(make_word(v, $urandom_range(0, 1), $urandom_range(0, 1),
                                $urandom_range(0, 1), $urandom_range(0, 1), width, prec));
            if (k == RANDOM_FIELDS / 2) wait_all_chars();
        end
        wait_all_chars();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data  = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_value_zero();
        test_case_and_prefix();
        test_padding_modes();
        in_idle  = 1'b0;
        out_idle = 1'b0;
        test_saturation();
        test_random_fields();

        // Room for the longest field plus the plan load, so stray words show up.
        repeat (80) @(posedge i_clk);
        if (err_count == 0) begin
            $display("tb_hex_field_formatter_unit: done, clean");
        end else begin
            $display("tb_hex_field_formatter_unit: done, errors");
        end
        $finish;
    end

endmodule
